// ===== rtl/arc_odometry_pose_tracker_core_assert.svh =====
// ----------------------------------------------------------------------------
// arc odometry pose tracker assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARC_ODOMETRY_POSE_TRACKER_CORE_ASSERT_SVH
`define ARC_ODOMETRY_POSE_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define AOPT_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aopt assertion failed");

// next-cycle implication
`define AOPT_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aopt assertion failed");

`endif

// ===== rtl/aopt_pkg.sv =====
// ----------------------------------------------------------------------------
// aopt_pkg
// shared constants, types and helper functions of the pose tracker
// ----------------------------------------------------------------------------
package aopt_pkg;

   localparam int TRIG_STEPS = 16;
   localparam int DIV_BITS   = 33;
   localparam int ATAN_N     = 24;
   localparam int IDX_W      = $clog2(ATAN_N);
   localparam int CNT_W      = $clog2(DIV_BITS + 1);
   localparam int ADDR_W     = 5;

   localparam logic signed [33:0] CORDIC_K       = 34'sd652032874;
   localparam logic signed [33:0] INV_PI_Q30     = 34'sd341782638;
   localparam logic signed [33:0] TURN_HALF      = 34'sd2147483648;
   localparam logic signed [33:0] TURN_QUARTER   = 34'sd1073741824;
   localparam logic signed [33:0] TURN_QUARTER_N = -34'sd1073741824;

   localparam logic        [15:0] DPC_RST = 16'd1573;
   localparam logic signed [22:0] SO_RST  = 23'sd368640;
   localparam logic signed [22:0] FO_RST  = 23'sd0;
   localparam logic signed [31:0] SX_RST  = -32'sd2359296;
   localparam logic signed [31:0] SY_RST  = -32'sd3932160;

   typedef enum logic [2:0] {
      REG_DPC, REG_SO, REG_FO, REG_SX, REG_SY
   } reg_idx_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_DF, MUL_DS, MUL_SINV, MUL_FDS, MUL_SSO, MUL_FDF, MUL_SFO,
      MUL_LYC, MUL_LXS, MUL_LYS, MUL_LXC
   } mul_sel_type;

   typedef enum logic [3:0] {
      TK_NONE, TK_DF, TK_DS, TK_NUM, TK_LX_F, TK_LX_O, TK_LY_F, TK_LY_O,
      TK_G_LOAD, TK_G_X, TK_G_Y
   } take_type;

   typedef enum logic {ANG_DH, ANG_MID} ang_sel_type;

   typedef struct packed {
      logic        [15:0] dpc;
      logic signed [22:0] so;
      logic signed [22:0] fo;
   } cfg_type;

   typedef struct packed {
      logic        ld_x;
      logic        ld_y;
      logic [31:0] value;
   } pos_load_type;

   typedef struct packed {
      logic              load_in;
      mul_sel_type       mul;
      take_type          take;
      logic              set_direct;
      logic              cor_start;
      ang_sel_type       ang_sel;
      logic              cor_step;
      logic [IDX_W-1:0]  iter;
      logic              div_step;
      logic              load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic dh_zero;
   } dp_stat_type;

   function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933405;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335086;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41721;
         5'd15:   r = 32'd20860;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2607;
         5'd19:   r = 32'd1303;
         5'd20:   r = 32'd651;
         5'd21:   r = 32'd325;
         5'd22:   r = 32'd162;
         5'd23:   r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/aopt_if.sv =====
// ----------------------------------------------------------------------------
// aopt channel interfaces
// valid/ready channels for the sample items and the pose items
// ----------------------------------------------------------------------------
interface aopt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] forward_count;
   logic [31:0] side_count;
   logic [15:0] heading;

   modport source (output valid, output forward_count, output side_count,
                   output heading, input ready);
   modport sink (input valid, input forward_count, input side_count,
                 input heading, output ready);
endinterface

interface aopt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_pos;
   logic [31:0] y_pos;
   logic [15:0] heading_out;

   modport source (output valid, output x_pos, output y_pos, output heading_out,
                   input ready);
   modport sink (input valid, input x_pos, input y_pos, input heading_out,
                 output ready);
endinterface

// ===== rtl/aopt_csr.sv =====
// ----------------------------------------------------------------------------
// aopt_csr
// apb register bank: wheel scale, wheel offsets and start position
// ----------------------------------------------------------------------------
module aopt_csr import aopt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg,
   output pos_load_type      pos_load
);

   logic [15:0]        dpc_ff;
   logic signed [22:0] so_ff;
   logic signed [22:0] fo_ff;
   logic [31:0]        sx_ff;
   logic [31:0]        sy_ff;
   logic               wr;
   reg_idx_type        idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_idx_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= DPC_RST;
         so_ff  <= SO_RST;
         fo_ff  <= FO_RST;
         sx_ff  <= SX_RST;
         sy_ff  <= SY_RST;
      end else if (wr) begin
         case (idx)
            REG_DPC: dpc_ff <= csr_pwdata[15:0];
            REG_SO:  so_ff  <= csr_pwdata[22:0];
            REG_FO:  fo_ff  <= csr_pwdata[22:0];
            REG_SX:  sx_ff  <= csr_pwdata;
            REG_SY:  sy_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DPC: csr_prdata = {16'd0, dpc_ff};
         REG_SO:  csr_prdata = {{9{so_ff[22]}}, so_ff};
         REG_FO:  csr_prdata = {{9{fo_ff[22]}}, fo_ff};
         REG_SX:  csr_prdata = sx_ff;
         REG_SY:  csr_prdata = sy_ff;
         default: csr_prdata = 32'd0;
      endcase
   end

   assign cfg.dpc = dpc_ff;
   assign cfg.so  = so_ff;
   assign cfg.fo  = fo_ff;

   assign pos_load.ld_x  = wr && (idx == REG_SX);
   assign pos_load.ld_y  = wr && (idx == REG_SY);
   assign pos_load.value = csr_pwdata;

endmodule

// ===== rtl/aopt_ctrl.sv =====
// ----------------------------------------------------------------------------
// aopt_ctrl
// sequencer: steps the shared multiplier, cordic and divider per item
// ----------------------------------------------------------------------------
`include "arc_odometry_pose_tracker_core_assert.svh"

module aopt_ctrl import aopt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DF, S_DS, S_DSW, S_SEL, S_COR1, S_INV, S_NUM, S_DIV,
      S_LX1, S_LX2, S_LY1, S_LY2, S_LYW, S_COR2,
      S_G1, S_G2, S_G3, S_G4, S_G5, S_DONE
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] iter_ff;
   logic [CNT_W-1:0] iter_in;
   logic             req_ready_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd            = '0;
      cmd.mul        = MUL_NONE;
      cmd.take       = TK_NONE;
      cmd.ang_sel    = ANG_DH;
      cmd.iter       = iter_ff[IDX_W-1:0];
      state_in       = state_ff;
      iter_in        = iter_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_in = 1'b1;
               state_in    = S_DF;
            end
         end
         S_DF: begin
            cmd.mul  = MUL_DF;
            state_in = S_DS;
         end
         S_DS: begin
            cmd.mul  = MUL_DS;
            cmd.take = TK_DF;
            state_in = S_DSW;
         end
         S_DSW: begin
            cmd.take = TK_DS;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.cor_start = 1'b1;
            iter_in       = '0;
            if (stat.dh_zero) begin
               cmd.set_direct = 1'b1;
               cmd.ang_sel    = ANG_MID;
               state_in       = S_COR2;
            end else begin
               cmd.ang_sel = ANG_DH;
               state_in    = S_COR1;
            end
         end
         S_COR1: begin
            cmd.cor_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == CNT_W'(TRIG_STEPS - 1)) begin
               state_in = S_INV;
            end
         end
         S_INV: begin
            cmd.mul  = MUL_SINV;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.take = TK_NUM;
            iter_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == CNT_W'(DIV_BITS - 1)) begin
               state_in = S_LX1;
            end
         end
         S_LX1: begin
            cmd.mul  = MUL_FDS;
            state_in = S_LX2;
         end
         S_LX2: begin
            cmd.mul  = MUL_SSO;
            cmd.take = TK_LX_F;
            state_in = S_LY1;
         end
         S_LY1: begin
            cmd.mul  = MUL_FDF;
            cmd.take = TK_LX_O;
            state_in = S_LY2;
         end
         S_LY2: begin
            cmd.mul  = MUL_SFO;
            cmd.take = TK_LY_F;
            state_in = S_LYW;
         end
         S_LYW: begin
            cmd.take      = TK_LY_O;
            cmd.cor_start = 1'b1;
            cmd.ang_sel   = ANG_MID;
            iter_in       = '0;
            state_in      = S_COR2;
         end
         S_COR2: begin
            cmd.cor_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == CNT_W'(TRIG_STEPS - 1)) begin
               state_in = S_G1;
            end
         end
         S_G1: begin
            cmd.mul  = MUL_LYC;
            state_in = S_G2;
         end
         S_G2: begin
            cmd.mul  = MUL_LXS;
            cmd.take = TK_G_LOAD;
            state_in = S_G3;
         end
         S_G3: begin
            cmd.mul  = MUL_LYS;
            cmd.take = TK_G_X;
            state_in = S_G4;
         end
         S_G4: begin
            cmd.mul  = MUL_LXC;
            cmd.take = TK_G_LOAD;
            state_in = S_G5;
         end
         S_G5: begin
            cmd.take = TK_G_Y;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         req_ready_ff <= (state_in == S_IDLE);
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `AOPT_ASSERT_NXT(a_accept_starts, req_valid && req_ready_ff, state_ff == S_DF)
   `AOPT_ASSERT_IMP(a_ready_only_idle, req_ready_ff, state_ff == S_IDLE)
   `AOPT_ASSERT_IMP(a_cordic_count, state_ff == S_COR1 || state_ff == S_COR2,
                    iter_ff < CNT_W'(TRIG_STEPS))
   `AOPT_ASSERT_IMP(a_no_overwrite, cmd.load_out, !rsp_valid_ff || rsp_ready)

endmodule

// ===== rtl/aopt_datapath.sv =====
// ----------------------------------------------------------------------------
// aopt_datapath
// sample state, shared multiplier, cordic, chord divider and pose update
// ----------------------------------------------------------------------------
module aopt_datapath import aopt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  pos_load_type pos_load,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  logic [31:0]  forward_count,
   input  logic [31:0]  side_count,
   input  logic [15:0]  heading,
   output logic [31:0]  x_pos,
   output logic [31:0]  y_pos,
   output logic [15:0]  heading_out
);

   logic [31:0]        last_f_ff, last_s_ff;
   logic [15:0]        last_h_ff, h_ff, dh_ff;
   logic signed [32:0] del_f_ff, del_s_ff;
   logic signed [31:0] d_f_ff, d_s_ff, lx_ff, ly_ff;
   logic signed [67:0] prod_ff, prod_in, gacc_ff;
   logic signed [37:0] acc_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               cneg_ff;
   logic [29:0]        rem_ff;
   logic [DIV_BITS-1:0] qsh_ff;
   logic [31:0]        pos_x_ff, pos_y_ff;
   logic [31:0]        x_out_ff, y_out_ff;
   logic [15:0]        h_out_ff;

   logic signed [33:0] mul_a, mul_b, cos_v, sin_v, abs_sin, f_v, za, at;
   logic signed [33:0] z0, sx, sy;
   logic               neg0;
   logic [31:0]        ang32;
   logic [16:0]        mid17;
   logic [15:0]        ad;
   logic [29:0]        den;
   logic [30:0]        trial;
   logic signed [67:0] lsum, gdiff, gsum;

   assign stat.dh_zero = (dh_ff == 16'd0);

   assign cos_v   = cneg_ff ? -cx_ff : cx_ff;
   assign sin_v   = cneg_ff ? -cy_ff : cy_ff;
   assign abs_sin = sin_v[33] ? -sin_v : sin_v;
   assign f_v     = (sin_v[33] != dh_ff[15]) ? -{1'b0, qsh_ff} : {1'b0, qsh_ff};
   assign ad      = dh_ff[15] ? -dh_ff : dh_ff;
   assign den     = {ad, 14'd0};
   assign trial   = {rem_ff, qsh_ff[DIV_BITS-1]};
   assign mid17   = {h_ff, 1'b0} - {dh_ff[15], dh_ff};

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul)
         MUL_DF:   begin mul_a = {del_f_ff[32], del_f_ff};     mul_b = {18'd0, cfg.dpc}; end
         MUL_DS:   begin mul_a = {del_s_ff[32], del_s_ff};     mul_b = {18'd0, cfg.dpc}; end
         MUL_SINV: begin mul_a = abs_sin;                      mul_b = INV_PI_Q30; end
         MUL_FDS:  begin mul_a = f_v; mul_b = {{2{d_s_ff[31]}}, d_s_ff}; end
         MUL_SSO:  begin mul_a = sin_v; mul_b = {{11{cfg.so[22]}}, cfg.so}; end
         MUL_FDF:  begin mul_a = f_v; mul_b = {{2{d_f_ff[31]}}, d_f_ff}; end
         MUL_SFO:  begin mul_a = sin_v; mul_b = {{11{cfg.fo[22]}}, cfg.fo}; end
         MUL_LYC:  begin mul_a = {{2{ly_ff[31]}}, ly_ff}; mul_b = cos_v; end
         MUL_LXS:  begin mul_a = {{2{lx_ff[31]}}, lx_ff}; mul_b = sin_v; end
         MUL_LYS:  begin mul_a = {{2{ly_ff[31]}}, ly_ff}; mul_b = sin_v; end
         MUL_LXC:  begin mul_a = {{2{lx_ff[31]}}, lx_ff}; mul_b = cos_v; end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // cordic start angle with quadrant fold
   always_comb begin
      ang32 = (cmd.ang_sel == ANG_MID) ? {mid17, 15'd0} : {dh_ff[15], dh_ff, 15'd0};
      za    = {{2{ang32[31]}}, ang32};
      neg0  = 1'b0;
      z0    = za;
      if (za > TURN_QUARTER) begin
         z0   = za - TURN_HALF;
         neg0 = 1'b1;
      end else if (za < TURN_QUARTER_N) begin
         z0   = za + TURN_HALF;
         neg0 = 1'b1;
      end
   end

   assign sx = cy_ff >>> cmd.iter;
   assign sy = cx_ff >>> cmd.iter;
   assign at = {2'b00, atan_turn(cmd.iter)};

   assign lsum  = {{30{acc_ff[37]}}, acc_ff} + {{29{prod_ff[67]}}, prod_ff[67:29]};
   assign gdiff = gacc_ff - prod_ff;
   assign gsum  = gacc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_f_ff <= '0;
         last_s_ff <= '0;
         last_h_ff <= '0;
         pos_x_ff  <= SX_RST;
         pos_y_ff  <= SY_RST;
      end else begin
         if (cmd.load_in) begin
            last_f_ff <= forward_count;
            last_s_ff <= side_count;
            last_h_ff <= heading;
         end
         if (pos_load.ld_x) begin
            pos_x_ff <= pos_load.value;
         end else if (cmd.take == TK_G_X) begin
            pos_x_ff <= pos_x_ff + gdiff[61:30];
         end
         if (pos_load.ld_y) begin
            pos_y_ff <= pos_load.value;
         end else if (cmd.take == TK_G_Y) begin
            pos_y_ff <= pos_y_ff + gsum[61:30];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_in) begin
         h_ff     <= heading;
         dh_ff    <= heading - last_h_ff;
         del_f_ff <= {forward_count[31], forward_count} - {last_f_ff[31], last_f_ff};
         del_s_ff <= {side_count[31], side_count} - {last_s_ff[31], last_s_ff};
      end
      case (cmd.take)
         TK_DF:     d_f_ff  <= sat32(prod_ff);
         TK_DS:     d_s_ff  <= sat32(prod_ff);
         TK_NUM: begin
            rem_ff <= {3'd0, prod_ff[59:DIV_BITS]};
            qsh_ff <= prod_ff[DIV_BITS-1:0];
         end
         TK_LX_F:   acc_ff  <= prod_ff[67:30];
         TK_LX_O:   lx_ff   <= sat32(lsum);
         TK_LY_F:   acc_ff  <= prod_ff[67:30];
         TK_LY_O:   ly_ff   <= sat32(lsum);
         TK_G_LOAD: gacc_ff <= prod_ff;
         default: ;
      endcase
      if (cmd.set_direct) begin
         lx_ff <= d_s_ff;
         ly_ff <= d_f_ff;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, den}) begin
            rem_ff <= 30'(trial - {1'b0, den});
            qsh_ff <= {qsh_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[29:0];
            qsh_ff <= {qsh_ff[DIV_BITS-2:0], 1'b0};
         end
      end
      if (cmd.cor_start) begin
         cx_ff   <= CORDIC_K;
         cy_ff   <= '0;
         cz_ff   <= z0;
         cneg_ff <= neg0;
      end else if (cmd.cor_step) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - sx;
            cy_ff <= cy_ff + sy;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + sx;
            cy_ff <= cy_ff - sy;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.load_out) begin
         x_out_ff <= pos_x_ff;
         y_out_ff <= pos_y_ff;
         h_out_ff <= h_ff;
      end
   end

   assign x_pos       = x_out_ff;
   assign y_pos       = y_out_ff;
   assign heading_out = h_out_ff;

endmodule

// ===== rtl/arc_odometry_pose_tracker_core.sv =====
// ----------------------------------------------------------------------------
// arc_odometry_pose_tracker_core
// two-wheel plus heading arc odometry, q16.16 pose, apb configuration
// ----------------------------------------------------------------------------
// Takes one sample item at a time and returns one pose item per sample. A
// sample with a heading change runs two passes of the shared 16-step cordic
// (chord sine, then mid-arc rotation) and the 33-step one-bit-per-cycle chord
// divider; a sample with an unchanged heading runs only the mid-arc pass. A
// single shared 34x34 multiplier is used for every product. The next sample is
// taken once the current result sits in the output register.
module arc_odometry_pose_tracker_core import aopt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   aopt_req_if.sink          req_if,
   aopt_rsp_if.source        rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type      cfg;
   pos_load_type pos_load;
   dp_cmd_type   cmd;
   dp_stat_type  stat;

   aopt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .pos_load    (pos_load)
   );

   aopt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   aopt_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .pos_load      (pos_load),
      .cmd           (cmd),
      .stat          (stat),
      .forward_count (req_if.forward_count),
      .side_count    (req_if.side_count),
      .heading       (req_if.heading),
      .x_pos         (rsp_if.x_pos),
      .y_pos         (rsp_if.y_pos),
      .heading_out   (rsp_if.heading_out)
   );

endmodule

// ===== verif/tb_arc_odometry_pose_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_arc_odometry_pose_tracker_core
// Drives sample items into the pose tracker and checks every pose item
// against a bit-exact odometry predictor: cordic sine and cosine, chord
// factor, saturation and wrapping. A directed table comes first, then random
// sample tracks under several register settings. Outside the quiet last phase
// both channels idle/stall at random; one long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_arc_odometry_pose_tracker_core;
   import aopt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] h;
   } pose_type;

   typedef struct {
      logic [31:0] fwd;
      logic [31:0] side;
      logic [15:0] hdg;
      bit          typed;
      logic [31:0] x;
      logic [31:0] y;
   } sample_row_type;

   localparam longint ATAN_TURN [0:23] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81};

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   aopt_req_if req_if ();
   aopt_rsp_if rsp_if ();

   arc_odometry_pose_tracker_core DUT (
      .clock, .reset, .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #5ms;
      $display("tb_arc_odometry_pose_tracker_core: done, errors");
      $finish;
   end

   // predictor state
   logic [15:0] dpc_q;
   longint      so_q, fo_q;
   logic [31:0] last_fwd, last_side, pos_x, pos_y;
   logic [15:0] last_hdg;

   pose_type pose_q[$];
   int errors = 0;
   int samples = 0;
   int poses = 0;
   bit quiet = 0;
   bit long_stall = 0;

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void sincos(input logic [31:0] ang, output longint c,
                                  output longint s);
      longint z, x, y, dx, dy;
      bit neg;
      z = longint'(ang);
      x = 652032874;
      y = 0;
      neg = 0;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         neg = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         neg = 1;
      end
      for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURN[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TURN[i];
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic pose_type track_pose(input logic [31:0] fwd,
                                           input logic [31:0] side,
                                           input logic [15:0] hdg);
      longint df, ds, dh, lx, ly, c, s, f, m;
      longint unsigned as_u, ad_u, fu;
      logic signed [15:0] dh16;
      logic [31:0] mid;
      pose_type p;
      df = sat_word((longint'($signed(fwd)) - longint'($signed(last_fwd)))
                    * longint'(dpc_q));
      ds = sat_word((longint'($signed(side)) - longint'($signed(last_side)))
                    * longint'(dpc_q));
      dh16 = hdg - last_hdg;
      dh = dh16;
      if (dh == 0) begin
         lx = ds;
         ly = df;
      end else begin
         sincos(32'(dh * 32768), c, s);
         as_u = (s < 0) ? -s : s;
         ad_u = (dh < 0) ? -dh : dh;
         fu = (as_u * 64'd341782638) / (ad_u << 14);
         f = longint'(fu);
         if ((s < 0) != (dh < 0)) f = -f;
         lx = sat_word((f * ds >>> 30) + (s * so_q >>> 29));
         ly = sat_word((f * df >>> 30) + (s * fo_q >>> 29));
      end
      m = (2 * longint'(hdg) - dh) & 64'h1FFFF;
      mid = 32'(m << 15);
      sincos(mid, c, s);
      pos_x += 32'((ly * c - lx * s) >>> 30);
      pos_y += 32'((ly * s + lx * c) >>> 30);
      last_fwd = fwd;
      last_side = side;
      last_hdg = hdg;
      p.x = pos_x;
      p.y = pos_y;
      p.h = hdg;
      return p;
   endfunction

   task automatic csr_write(input int idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_W'(idx * 4);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_DPC: dpc_q = val[15:0];
         REG_SO:  so_q = longint'($signed(val[22:0]));
         REG_FO:  fo_q = longint'($signed(val[22:0]));
         REG_SX:  pos_x = val;
         REG_SY:  pos_y = val;
         default: ;
      endcase
   endtask

   task automatic send_sample(input logic [31:0] fwd, input logic [31:0] side,
                              input logic [15:0] hdg, input bit typed,
                              input logic [31:0] tx, input logic [31:0] ty);
      pose_type p;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.forward_count <= fwd;
      req_if.side_count <= side;
      req_if.heading <= hdg;
      do @(posedge clock); while (!req_if.ready);
      p = track_pose(fwd, side, hdg);
      if (typed) begin
         p.x = tx;
         p.y = ty;
      end
      pose_q.push_back(p);
      samples++;
   endtask

   task automatic drain;
      req_if.valid <= 0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // pose item checker
   always @(posedge clock) begin
      pose_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         poses++;
         if (pose_q.size() == 0) begin
            $error("pose item with nothing expected");
            errors++;
         end else begin
            e = pose_q.pop_front();
            if (rsp_if.x_pos !== e.x) begin
               $error("x_pos expected %0d got %0d", $signed(e.x), $signed(rsp_if.x_pos));
               errors++;
            end
            if (rsp_if.y_pos !== e.y) begin
               $error("y_pos expected %0d got %0d", $signed(e.y), $signed(rsp_if.y_pos));
               errors++;
            end
            if (rsp_if.heading_out !== e.h) begin
               $error("heading_out expected %0d got %0d", e.h, rsp_if.heading_out);
               errors++;
            end
         end
      end
   end

   // pose item receiver
   initial begin
      rsp_if.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_stall) begin
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
            long_stall = 0;
            rsp_if.ready <= 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_if.ready <= 1;
         end else begin
            rsp_if.ready <= 1;
         end
      end
   end

   sample_row_type rows[$];
   logic [31:0] f_cur, s_cur;
   logic [15:0] h_cur;

   initial begin
      req_if.valid = 0;
      req_if.forward_count = 0;
      req_if.side_count = 0;
      req_if.heading = 0;
      dpc_q = DPC_RST;
      so_q = SO_RST;
      fo_q = FO_RST;
      last_fwd = 0;
      last_side = 0;
      last_hdg = 0;
      pos_x = SX_RST;
      pos_y = SY_RST;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table
      rows = '{
         '{32'd0, 32'd0, 16'd0, 1, SX_RST, SY_RST},
         '{32'd0, 32'd0, 16'd0, 1, SX_RST, SY_RST},
         '{32'd10, 32'd5, 16'd0, 0, 0, 0},
         '{32'd20, 32'd5, 16'd1, 0, 0, 0},
         '{32'd20, 32'd7, 16'd0, 0, 0, 0},
         '{32'd30, 32'd3, 16'd32768, 0, 0, 0},
         '{32'd30, 32'd3, 16'd0, 0, 0, 0},
         '{32'd40, 32'd40, 16'd65535, 0, 0, 0},
         '{32'd50, 32'd60, 16'd16384, 0, 0, 0},
         '{32'h7fffffff, 32'h80000000, 16'd16000, 0, 0, 0},
         '{32'h80000000, 32'h7fffffff, 16'd48000, 0, 0, 0},
         '{32'h7fffffff, 32'h80000000, 16'd48000, 0, 0, 0},
         '{32'hffffffff, 32'hffffffff, 16'd15232, 0, 0, 0},
         '{32'd0, 32'd0, 16'd47999, 0, 0, 0}
      };
      foreach (rows[i])
         send_sample(rows[i].fwd, rows[i].side, rows[i].hdg, rows[i].typed,
                     rows[i].x, rows[i].y);
      long_stall = 1;
      repeat (12) send_sample($urandom, $urandom, 16'($urandom), 0, 0, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_DPC, 32'd0);
               csr_write(REG_SO, 32'h00200000);
               csr_write(REG_FO, -32'sd2097152);
               csr_write(REG_SX, 32'h7fffffff);
               csr_write(REG_SY, 32'h80000000);
               csr_write(5, 32'h12345678);
            end
            1: begin
               csr_write(REG_DPC, 32'd65535);
               csr_write(REG_SO, -32'sd2097152);
               csr_write(REG_FO, 32'h00200000);
               csr_write(REG_SX, 32'h80000000);
               csr_write(REG_SY, 32'h7fffffff);
            end
            2: begin
               csr_write(REG_DPC, 32'd1);
               csr_write(REG_SO, 32'd0);
               csr_write(REG_FO, 32'd0);
               csr_write(REG_SX, 32'd0);
               csr_write(REG_SY, 32'd0);
            end
            default: begin
               quiet = 1;
               csr_write(REG_DPC, $urandom_range(1, 65535));
               csr_write(REG_SO, $urandom_range(0, 4194304) - 2097152);
               csr_write(REG_FO, $urandom_range(0, 4194304) - 2097152);
               csr_write(REG_SX, $urandom);
               csr_write(REG_SY, $urandom);
            end
         endcase
         f_cur = last_fwd;
         s_cur = last_side;
         h_cur = last_hdg;
         for (int n = 0; n < 445; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  f_cur = $urandom; s_cur = $urandom; h_cur = 16'($urandom);
               end
               1: begin
                  f_cur += 32'($urandom_range(0, 2000) - 1000);
                  s_cur += 32'($urandom_range(0, 2000) - 1000);
               end
               2: begin
                  h_cur += 16'($urandom_range(0, 6) - 3);
               end
               default: begin
                  f_cur += 32'($urandom_range(0, 400) - 200);
                  s_cur += 32'($urandom_range(0, 400) - 200);
                  h_cur += 16'($urandom_range(0, 4000) - 2000);
               end
            endcase
            send_sample(f_cur, s_cur, h_cur, 0, 0, 0);
         end
         drain();
      end

      $display("covered %0d samples, %0d poses checked", samples, poses);
      $display("five register settings incl. extremes, one long output stall");
      if (errors == 0) begin
         $display("tb_arc_odometry_pose_tracker_core: done, clean");
      end else begin
         $display("tb_arc_odometry_pose_tracker_core: done, errors");
      end
      $finish;
   end
endmodule
